/* src/atr_pkg.sv */
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types, codes and sizes of the address type registry.
// ----------------------------------------------------------------------------
package atr_pkg;

    // BINS is a power of two so that the bin is the low address bits
    localparam int BINS = 64;
    localparam int WAYS = 8;

    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_VERIFY   = 2'd1;
    localparam logic [1:0] KIND_DELETE   = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH  = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_NULL      = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [7:0]  type_tag;
        logic [63:0] handle;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  type_tag;
        logic [63:0] handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] handle_out;
        logic [7:0]  found_type;
    } resp_t;

    function automatic logic [BIN_W-1:0] bin_of(input logic [31:0] address);
        logic [BIN_W-1:0] bin;
        bin = (BINS > 1) ? address[BIN_W-1:0] : '0;
        return bin;
    endfunction

endpackage

/* src/atr_ram.sv */
// ----------------------------------------------------------------------------
// atr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module atr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/atr_bin_update.sv */
// ----------------------------------------------------------------------------
// atr_bin_update
// Compares all ways of one bin row against a request and builds the
// written-back row and the response.
// ----------------------------------------------------------------------------
module atr_bin_update (
    input  atr_pkg::row_t  row_in,
    input  atr_pkg::req_t  req,
    output atr_pkg::row_t  row_out,
    output logic           row_we,
    output atr_pkg::resp_t resp
);
    import atr_pkg::*;

    logic [WAYS-1:0]  hit_vec;
    logic [WAYS-1:0]  free_vec;
    logic [WAY_W-1:0] hit_idx;
    logic [WAY_W-1:0] free_idx;
    way_t             hit_way;
    way_t             new_way;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = row_in[w].valid && (row_in[w].key == req.address);
            free_vec[w] = !row_in[w].valid;
        end
        // descending so the lowest way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_idx = WAY_W'(w);
            end
        end
    end

    assign hit_way = row_in[hit_idx];

    always_comb begin
        new_way.valid    = 1'b1;
        new_way.key      = req.address;
        new_way.type_tag = req.type_tag;
        new_way.handle   = req.handle;
    end

    always_comb begin
        row_out     = row_in;
        row_we      = 1'b0;
        resp.status     = STATUS_NOT_FOUND;
        resp.handle_out = '0;
        resp.found_type = '0;
        case (req.kind)
            KIND_REGISTER: begin
                if (req.address == '0) begin
                    resp.status = STATUS_NULL;
                end else if (|hit_vec) begin
                    resp.found_type           = hit_way.type_tag;
                    row_out[hit_idx].type_tag = req.type_tag;
                    row_we                    = 1'b1;
                    resp.status               = STATUS_OK;
                end else if (|free_vec) begin
                    row_out[free_idx] = new_way;
                    row_we            = 1'b1;
                    resp.status       = STATUS_OK;
                end else begin
                    resp.status = STATUS_FULL;
                end
            end
            KIND_VERIFY: begin
                if (|hit_vec) begin
                    resp.found_type = hit_way.type_tag;
                    if (hit_way.type_tag == req.type_tag) begin
                        resp.handle_out = hit_way.handle;
                        resp.status     = STATUS_OK;
                    end else begin
                        resp.status = STATUS_MISMATCH;
                    end
                end
            end
            KIND_DELETE: begin
                if (|hit_vec) begin
                    resp.found_type        = hit_way.type_tag;
                    row_out[hit_idx].valid = 1'b0;
                    row_we                 = 1'b1;
                    resp.status            = STATUS_OK;
                end
            end
            default: begin
                resp.status = STATUS_NOT_FOUND;
            end
        endcase
    end

endmodule

/* src/address_type_registry.sv */
// ----------------------------------------------------------------------------
// address_type_registry
// Hashed registry of addresses with a type tag and a handle per entry.
// ----------------------------------------------------------------------------
// For each item the block reads its bin row (all ways of the bin in one
// word) from the single-port table memory, then compares every way and
// writes the row back where the request changes it. Items are handled one at
// a time; the next item is taken as soon as the previous result sits in the
// output register, even if it has not been taken yet, but its compare waits
// for that register to drain. After reset the block clears the valid marks
// of every bin, one row a cycle, with s_ready low.
module address_type_registry (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_address,
    input  logic [7:0]  s_type_tag,
    input  logic [63:0] s_handle,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_handle_out,
    output logic [7:0]  m_found_type
);
    import atr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [BIN_W-1:0] clr_idx_reg, clr_idx_next;
    req_t             req_reg;
    logic             m_valid_reg, m_valid_next;
    resp_t            resp_reg;

    logic             accept;
    logic             out_free;
    logic             finish;

    logic             ram_en;
    logic             ram_we;
    logic [BIN_W-1:0] ram_addr;
    row_t             ram_wdata;
    row_t             ram_rdata;

    row_t             row_new;
    logic             row_we;
    resp_t            resp_new;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_LOOKUP) && out_free;

    atr_ram #(
        .WIDTH(ROW_W),
        .DEPTH(BINS)
    ) u_table (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    atr_bin_update u_update (
        .row_in (ram_rdata),
        .req    (req_reg),
        .row_out(row_new),
        .row_we (row_we),
        .resp   (resp_new)
    );

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = bin_of(req_reg.address);
        ram_wdata = row_new;
        if (state_reg == S_CLEAR) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_idx_reg;
            ram_wdata = '0;
        end else if (accept) begin
            ram_en   = 1'b1;
            ram_addr = bin_of(s_address);
        end else if (finish) begin
            ram_en = row_we;
            ram_we = row_we;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == BIN_W'(BINS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.kind     <= s_kind;
            req_reg.address  <= s_address;
            req_reg.type_tag <= s_type_tag;
            req_reg.handle   <= s_handle;
        end
        if (finish) begin
            resp_reg <= resp_new;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = resp_reg.status;
    assign m_handle_out = resp_reg.handle_out;
    assign m_found_type = resp_reg.found_type;

endmodule

/* src/atr_checker.sv */
// ----------------------------------------------------------------------------
// atr_checker
// Port-level checks of the address type registry, bound to the top level.
// ----------------------------------------------------------------------------
module atr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [63:0] m_handle_out,
    input logic [7:0]  m_found_type
);
    import atr_pkg::*;

    // a result waiting for the sink holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_handle_out) && $stable(m_found_type))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous one in flight");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK) || (m_status == STATUS_NOT_FOUND)
            || (m_status == STATUS_MISMATCH) || (m_status == STATUS_FULL)
            || (m_status == STATUS_NULL))
        else $error("undefined status code");

    // handle only comes back with an OK status
    a_handle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> (m_handle_out == '0))
        else $error("handle returned with failing status");

    a_type_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == STATUS_NOT_FOUND) || (m_status == STATUS_FULL)
            || (m_status == STATUS_NULL)) |-> (m_found_type == '0))
        else $error("type reported without a matching entry");

endmodule

bind address_type_registry atr_checker u_atr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_handle_out(m_handle_out),
    .m_found_type(m_found_type)
);
